// File: src/spq_pkg.sv
package spq_pkg;

    // Queue depth and the width of the entry counter
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One held entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] pri;
    } t_entry;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

// File: src/stable_min_priority_queue_unit.sv
// Channel | Direction | Handshake                  | Word
// in      | into unit | i_in_valid / o_in_ready    | i_opcode, i_item_value, i_item_priority
// out     | from unit | o_out_valid / i_out_ready  | o_status, o_out_value, o_out_priority,
//         |           |                            | o_occupancy
//
// One word is taken per cycle while the input is ready; its result appears
// in the output register on the next cycle. Every cell of the sorted chain
// decides combinationally from its own compare and its left neighbor's.
// Out of reset, input stalls only while a result is held and the output
// side is not ready. Reset clears the entry count and the output valid and
// holds the input not ready; cell contents are not cleared.
module stable_min_priority_queue_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic signed [spq_pkg::DATA_W-1:0] i_item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] i_item_priority,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic        [1:0]                 o_status,
    output logic signed [spq_pkg::DATA_W-1:0] o_out_value,
    output logic signed [spq_pkg::DATA_W-1:0] o_out_priority,
    output logic        [spq_pkg::OCC_W-1:0]  o_occupancy
);
    import spq_pkg::*;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    t_cell_ctl          w_ctl;
    t_entry             w_new;
    t_entry             w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_after;
    logic [CAPACITY-1:0] w_held;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_status;
    t_status            n_status;
    t_entry             r_out;
    t_entry             n_out;

    // Accept while out of reset and the output register is free or being drained
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    assign w_ctl.enq = w_accept && (i_opcode == OP_ENQ) && !w_full;
    assign w_ctl.deq = w_accept && (i_opcode == OP_DEQ) && !w_empty;

    assign w_new.value = i_item_value;
    assign w_new.pri   = i_item_priority;

    // Build the chain of cells, head at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_held[g] = (CNT_W'(g) < r_count);

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_left       ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g-1]),
            .i_right      ((g == CAPACITY-1) ? w_new
                                             : w_entry[(g == CAPACITY-1) ? g : g+1]),
            .i_left_after ((g == 0) ? 1'b1 : w_after[(g == 0) ? 0 : g-1]),
            .i_held       (w_held[g]),
            .o_entry      (w_entry[g]),
            .o_after      (w_after[g])
        );
    end

    // Advance the count and load the result word
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_DONE;
            n_out       = '0;
            if (i_opcode == OP_ENQ) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out   = w_entry[0];
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Drive the result ports; occupancy is the count held after this word
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_out.value;
    assign o_out_priority = r_out.pri;
    assign o_occupancy    = OCC_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted word gave no result");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |->
            (o_out_value == '0 && o_out_priority == '0))
        else $error("failed word carries nonzero entry");

    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_DEQ) && w_empty) |=>
            (o_status == ST_EMPTY && r_count == $past(r_count)))
        else $error("dequeue on empty changed state");

    a_full_enq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_ENQ) && w_full) |=>
            (o_status == ST_FULL && r_count == $past(r_count)))
        else $error("enqueue into full changed state");

endmodule

// File: src/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    input  logic               i_left_after,
    input  logic               i_held,
    output spq_pkg::t_entry    o_entry,
    output logic               o_after
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // New word goes behind this entry when it is held and not ranked later
    assign o_after = i_held && (r_entry.pri <= i_new.pri);
    assign o_entry = r_entry;

    // Keep, take the new word, shift right on insert, or shift left on removal
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (o_after) begin
                n_entry = r_entry;
            end else if (i_left_after) begin
                n_entry = i_new;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
